@@ src/mpsrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsrb_pkg
// Shared types and constants for the multi-port serial ring buffers.
// ----------------------------------------------------------------------------
package mpsrb_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned PORT_W  = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_TX_WRITE = 2'd0,
      CMD_TX_READY = 2'd1,
      CMD_RX_STORE = 2'd2,
      CMD_RX_READ  = 2'd3
   } cmd_type;

   // Status that travels beside the ring read data to the response register.
   typedef struct packed {
      logic               tx_valid;   // tx ring read carries a dequeued byte
      logic               rx_valid;   // rx ring read carries a written byte
      logic               tx_request;
      logic               tx_empty;
      logic [COUNT_W-1:0] rx_count;
   } meta_type;

endpackage

@@ src/mpsrb_ring_mem.sv @@
// ----------------------------------------------------------------------------
// mpsrb_ring_mem
// Single-port byte store for the rings, registered read data.
// ----------------------------------------------------------------------------
module mpsrb_ring_mem #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic                                   rd_en,
   input  logic [$clog2(DEPTH)-1:0]               addr,
   input  logic [mpsrb_pkg::BYTE_W-1:0]           wr_data,
   output logic [mpsrb_pkg::BYTE_W-1:0]           rd_data
);
   import mpsrb_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      // hold the last read while no new read is issued
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mpsrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpsrb_ctrl
// Per-port ring pointers and flags; decodes one command into ring accesses.
// ----------------------------------------------------------------------------
module mpsrb_ctrl #(
   parameter int unsigned PORT_COUNT = 4,
   parameter int unsigned TX_DEPTH   = 64,
   parameter int unsigned RX_DEPTH   = 64
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         acc,
   input  logic [mpsrb_pkg::CMD_W-1:0]                  cmd,
   input  logic [mpsrb_pkg::PORT_W-1:0]                 port_index,
   output logic                                         tx_wr_en,
   output logic                                         tx_rd_en,
   output logic [$clog2(PORT_COUNT*TX_DEPTH)-1:0]       tx_addr,
   output logic                                         rx_wr_en,
   output logic                                         rx_rd_en,
   output logic [$clog2(PORT_COUNT*RX_DEPTH)-1:0]       rx_addr,
   output mpsrb_pkg::meta_type                          meta
);
   import mpsrb_pkg::*;

   localparam int unsigned PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int unsigned TX_PW  = $clog2(TX_DEPTH);
   localparam int unsigned RX_PW  = $clog2(RX_DEPTH);
   localparam int unsigned RX_CW  = RX_PW + 1;
   localparam int unsigned TX_AW  = $clog2(PORT_COUNT*TX_DEPTH);
   localparam int unsigned RX_AW  = $clog2(PORT_COUNT*RX_DEPTH);

   logic [TX_PW-1:0] tx_head_ff [PORT_COUNT];
   logic [TX_PW-1:0] tx_tail_ff [PORT_COUNT];
   logic [RX_PW-1:0] rx_head_ff [PORT_COUNT];
   logic [RX_PW-1:0] rx_tail_ff [PORT_COUNT];
   logic             flag_ff    [PORT_COUNT];
   logic             wrap_ff    [PORT_COUNT];   // rx head has passed the end once

   logic [TX_PW-1:0] tx_head_in, tx_tail_in, tx_ptr;
   logic [RX_PW-1:0] rx_head_in, rx_tail_in, rx_ptr;
   logic             flag_in, wrap_in;
   logic             tx_valid, rx_valid;
   logic [RX_CW-1:0] rx_diff;
   logic [PIDX_W-1:0] port_sel;
   logic             port_ok;

   function automatic logic [TX_PW-1:0] tx_next(input logic [TX_PW-1:0] p);
      return (p == TX_PW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [RX_PW-1:0] rx_next(input logic [RX_PW-1:0] p);
      return (p == RX_PW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign port_sel = PIDX_W'(port_index);
   assign port_ok  = (32'(port_index) < PORT_COUNT);

   always_comb begin
      tx_head_in = '0;
      tx_tail_in = '0;
      rx_head_in = '0;
      rx_tail_in = '0;
      flag_in    = 1'b0;
      wrap_in    = 1'b0;
      tx_ptr     = '0;
      rx_ptr     = '0;
      tx_wr_en   = 1'b0;
      tx_rd_en   = 1'b0;
      rx_wr_en   = 1'b0;
      rx_rd_en   = 1'b0;
      tx_valid   = 1'b0;
      rx_valid   = 1'b0;
      if (port_ok) begin
         tx_head_in = tx_head_ff[port_sel];
         tx_tail_in = tx_tail_ff[port_sel];
         rx_head_in = rx_head_ff[port_sel];
         rx_tail_in = rx_tail_ff[port_sel];
         flag_in    = flag_ff[port_sel];
         wrap_in    = wrap_ff[port_sel];
         unique case (cmd_type'(cmd))
            CMD_TX_WRITE: begin
               // advance first, then store at the new head
               tx_head_in = tx_next(tx_head_in);
               tx_ptr     = tx_head_in;
               tx_wr_en   = acc;
               flag_in    = 1'b1;
            end
            CMD_TX_READY: begin
               if (tx_head_in != tx_tail_in) begin
                  tx_tail_in = tx_next(tx_tail_in);
                  tx_ptr     = tx_tail_in;
                  tx_rd_en   = acc;
                  tx_valid   = 1'b1;
               end
               if (tx_tail_in == tx_head_in) begin
                  flag_in = 1'b0;
               end
            end
            CMD_RX_STORE: begin
               rx_ptr   = rx_head_in;
               rx_wr_en = acc;
               if (rx_head_in == RX_PW'(RX_DEPTH - 1)) begin
                  wrap_in = 1'b1;
               end
               rx_head_in = rx_next(rx_head_in);
            end
            CMD_RX_READ: begin
               rx_ptr   = rx_tail_in;
               rx_rd_en = acc;
               // the tail entry is unwritten only when empty before first wrap
               rx_valid = wrap_in || (rx_head_in != rx_tail_in);
               if (rx_head_in != rx_tail_in) begin
                  rx_tail_in = rx_next(rx_tail_in);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (rx_head_in >= rx_tail_in) begin
         rx_diff = {1'b0, rx_head_in} - {1'b0, rx_tail_in};
      end else begin
         rx_diff = {1'b0, rx_head_in} + RX_CW'(RX_DEPTH) - {1'b0, rx_tail_in};
      end
   end

   assign tx_addr = TX_AW'(port_sel) * TX_AW'(TX_DEPTH) + TX_AW'(tx_ptr);
   assign rx_addr = RX_AW'(port_sel) * RX_AW'(RX_DEPTH) + RX_AW'(rx_ptr);

   always_comb begin
      meta = '0;
      if (port_ok) begin
         meta.tx_valid   = tx_valid;
         meta.rx_valid   = rx_valid;
         meta.tx_request = flag_in;
         meta.tx_empty   = (tx_head_in == tx_tail_in);
         meta.rx_count   = COUNT_W'(rx_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_COUNT; i++) begin
            tx_head_ff[i] <= '0;
            tx_tail_ff[i] <= '0;
            rx_head_ff[i] <= '0;
            rx_tail_ff[i] <= '0;
            flag_ff[i]    <= 1'b0;
            wrap_ff[i]    <= 1'b0;
         end
      end else if (acc && port_ok) begin
         tx_head_ff[port_sel] <= tx_head_in;
         tx_tail_ff[port_sel] <= tx_tail_in;
         rx_head_ff[port_sel] <= rx_head_in;
         rx_tail_ff[port_sel] <= rx_tail_in;
         flag_ff[port_sel]    <= flag_in;
         wrap_ff[port_sel]    <= wrap_in;
      end
   end

endmodule

@@ src/multi_port_serial_ring_buffers.sv @@
// ----------------------------------------------------------------------------
// multi_port_serial_ring_buffers
// Transmit and receive byte rings for several serial ports, one command a word.
// ----------------------------------------------------------------------------
// Response: the response word is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response side does not stall;
//    the ring stores have a single port and registered read data.
// Reset: pointers, transmit-request flags and the response valid clear
//    synchronously. Ring contents are not swept; a per-port wrap flag makes
//    receive entries never written since reset read as zero, so no clearing pass.
module multi_port_serial_ring_buffers #(
   parameter int unsigned PORT_COUNT = 4,
   parameter int unsigned TX_DEPTH   = 64,
   parameter int unsigned RX_DEPTH   = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mpsrb_pkg::CMD_W-1:0]      req_command,
   input  logic [mpsrb_pkg::PORT_W-1:0]     req_port_index,
   input  logic [mpsrb_pkg::BYTE_W-1:0]     req_data_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mpsrb_pkg::BYTE_W-1:0]     rsp_read_data,
   output logic [mpsrb_pkg::BYTE_W-1:0]     rsp_tx_byte,
   output logic                             rsp_tx_valid,
   output logic                             rsp_tx_request,
   output logic                             rsp_tx_empty,
   output logic [mpsrb_pkg::COUNT_W-1:0]    rsp_rx_count
);
   import mpsrb_pkg::*;

   localparam int unsigned TX_AW = $clog2(PORT_COUNT*TX_DEPTH);
   localparam int unsigned RX_AW = $clog2(PORT_COUNT*RX_DEPTH);

   logic              acc;
   logic              tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
   logic [TX_AW-1:0]  tx_addr;
   logic [RX_AW-1:0]  rx_addr;
   logic [BYTE_W-1:0] tx_q, rx_q;
   meta_type          meta;
   meta_type          meta_ff;
   logic              rsp_valid_ff;

   // Take a new word whenever the response register is empty or drains now.
   // The ring read registers only load on accept, so a stalled response holds.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign acc       = req_valid && req_ready;

   // Pointer state and command decode: pointers update at accept, so the next
   // word sees them at once and no forwarding is needed.
   mpsrb_ctrl #(
      .PORT_COUNT (PORT_COUNT),
      .TX_DEPTH   (TX_DEPTH),
      .RX_DEPTH   (RX_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .cmd        (req_command),
      .port_index (req_port_index),
      .tx_wr_en   (tx_wr_en),
      .tx_rd_en   (tx_rd_en),
      .tx_addr    (tx_addr),
      .rx_wr_en   (rx_wr_en),
      .rx_rd_en   (rx_rd_en),
      .rx_addr    (rx_addr),
      .meta       (meta)
   );

   // Transmit rings of all ports, packed port after port.
   mpsrb_ring_mem #(
      .DEPTH (PORT_COUNT*TX_DEPTH)
   ) u_tx_mem (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .rd_en   (tx_rd_en),
      .addr    (tx_addr),
      .wr_data (req_data_in),
      .rd_data (tx_q)
   );

   // Receive rings of all ports, packed port after port.
   mpsrb_ring_mem #(
      .DEPTH (PORT_COUNT*RX_DEPTH)
   ) u_rx_mem (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .rd_en   (rx_rd_en),
      .addr    (rx_addr),
      .wr_data (req_data_in),
      .rd_data (rx_q)
   );

   // Response register: status beside the ring read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (acc) begin
         meta_ff <= meta;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   // Drop ring data that the command did not produce.
   assign rsp_read_data  = meta_ff.rx_valid ? rx_q : '0;
   assign rsp_tx_byte    = meta_ff.tx_valid ? tx_q : '0;
   assign rsp_tx_valid   = meta_ff.tx_valid;
   assign rsp_tx_request = meta_ff.tx_request;
   assign rsp_tx_empty   = meta_ff.tx_empty;
   assign rsp_rx_count   = meta_ff.rx_count;

   // A dequeued transmit byte never comes with receive data.
   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_read_data == '0)
      else $error("transmit and receive data in one response");

   // A transmit ring holding bytes always has its request flag set.
   a_nonempty_requests: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_empty |-> rsp_tx_request)
      else $error("non-empty transmit ring without request flag");

   // An empty response register never stalls the request side.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // Nothing is presented right after reset.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ tb/ring_status_checker.sv @@
// ----------------------------------------------------------------------------
// ring_status_checker
// Watches both channels of the serial ring buffers. It keeps its own copy of
// every port's rings and compares each response word with the status due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ring_status_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [mpsrb_pkg::CMD_W-1:0]   req_command,
   input  logic [mpsrb_pkg::PORT_W-1:0]  req_port_index,
   input  logic [mpsrb_pkg::BYTE_W-1:0]  req_data_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [mpsrb_pkg::BYTE_W-1:0]  rsp_read_data,
   input  logic [mpsrb_pkg::BYTE_W-1:0]  rsp_tx_byte,
   input  logic                          rsp_tx_valid,
   input  logic                          rsp_tx_request,
   input  logic                          rsp_tx_empty,
   input  logic [mpsrb_pkg::COUNT_W-1:0] rsp_rx_count,
   output int unsigned                   failures,
   output int unsigned                   outstanding
);

   import mpsrb_pkg::*;

   localparam int unsigned PORTS      = 4;
   localparam int unsigned RING_DEPTH = 64;
   localparam int unsigned PTR_W      = 6;
   localparam int unsigned MAX_LINES  = 100;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_valid;
      logic               tx_request;
      logic               tx_empty;
      logic [COUNT_W-1:0] rx_count;
   } port_status_type;

   logic [BYTE_W-1:0] tx_fifo_mem [PORTS][RING_DEPTH];
   logic [BYTE_W-1:0] rx_fifo_mem [PORTS][RING_DEPTH];
   logic [PTR_W-1:0]  tx_wr_ptr [PORTS];
   logic [PTR_W-1:0]  tx_rd_ptr [PORTS];
   logic [PTR_W-1:0]  rx_wr_ptr [PORTS];
   logic [PTR_W-1:0]  rx_rd_ptr [PORTS];
   logic              tx_irq_en [PORTS];

   port_status_type due_status_q [$];
   port_status_type want;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string field, input int got, input int due);
      failures++;
      if (failures <= MAX_LINES)
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, due);
   endtask

   // Apply one command to the shadow rings and return the status it yields.
   function automatic port_status_type next_port_status(input cmd_type cmd,
                                                        input logic [PORT_W-1:0] port,
                                                        input logic [BYTE_W-1:0] data);
      port_status_type r;
      logic [PTR_W-1:0] ptr;
      r = '0;
      case (cmd)
         CMD_TX_WRITE: begin
            ptr = tx_wr_ptr[port] + 1'b1;
            tx_fifo_mem[port][ptr] = data;
            tx_wr_ptr[port] = ptr;
            tx_irq_en[port] = 1'b1;
         end
         CMD_TX_READY: begin
            ptr = tx_rd_ptr[port];
            if (tx_wr_ptr[port] != ptr) begin
               ptr = ptr + 1'b1;
               r.tx_byte = tx_fifo_mem[port][ptr];
               r.tx_valid = 1'b1;
               tx_rd_ptr[port] = ptr;
            end
            if (ptr == tx_wr_ptr[port])
               tx_irq_en[port] = 1'b0;
         end
         CMD_RX_STORE: begin
            rx_fifo_mem[port][rx_wr_ptr[port]] = data;
            rx_wr_ptr[port] = rx_wr_ptr[port] + 1'b1;
         end
         CMD_RX_READ: begin
            // stale byte comes back when the ring is empty
            r.read_data = rx_fifo_mem[port][rx_rd_ptr[port]];
            if (rx_wr_ptr[port] != rx_rd_ptr[port])
               rx_rd_ptr[port] = rx_rd_ptr[port] + 1'b1;
         end
      endcase
      r.tx_request = tx_irq_en[port];
      r.tx_empty   = (tx_wr_ptr[port] == tx_rd_ptr[port]);
      r.rx_count   = rx_wr_ptr[port] - rx_rd_ptr[port];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PORTS; p++) begin
            for (int e = 0; e < RING_DEPTH; e++) begin
               tx_fifo_mem[p][e] = '0;
               rx_fifo_mem[p][e] = '0;
            end
            tx_wr_ptr[p] = '0;
            tx_rd_ptr[p] = '0;
            rx_wr_ptr[p] = '0;
            rx_rd_ptr[p] = '0;
            tx_irq_en[p] = 1'b0;
         end
         due_status_q.delete();
      end else begin
         // retire the response first so an early word never meets its own item
         if (rsp_valid && rsp_ready) begin
            if (due_status_q.size() == 0) begin
               report_mismatch("word with nothing due", 1, 0);
            end else begin
               want = due_status_q.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", int'(rsp_read_data), int'(want.read_data));
               if (rsp_tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", int'(rsp_tx_byte), int'(want.tx_byte));
               if (rsp_tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", int'(rsp_tx_valid), int'(want.tx_valid));
               if (rsp_tx_request !== want.tx_request)
                  report_mismatch("tx_request", int'(rsp_tx_request),
                                  int'(want.tx_request));
               if (rsp_tx_empty !== want.tx_empty)
                  report_mismatch("tx_empty", int'(rsp_tx_empty), int'(want.tx_empty));
               if (rsp_rx_count !== want.rx_count)
                  report_mismatch("rx_count", int'(rsp_rx_count), int'(want.rx_count));
            end
         end
         if (req_valid && req_ready)
            due_status_q.push_back(next_port_status(cmd_type'(req_command),
                                                    req_port_index, req_data_in));
      end
      outstanding <= due_status_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives command words into the serial ring buffers under several idling
// patterns, with a long response stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import mpsrb_pkg::*;

   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PHASE_WORDS  = 500;
   localparam int unsigned DRAIN_LIMIT  = 20000;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned RUN_LIMIT_NS = 2000000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic [PORT_W-1:0]   req_port_index;
   logic [BYTE_W-1:0]   req_data_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic [BYTE_W-1:0]   rsp_tx_byte;
   logic                rsp_tx_valid;
   logic                rsp_tx_request;
   logic                rsp_tx_empty;
   logic [COUNT_W-1:0]  rsp_rx_count;

   int unsigned failures;
   int unsigned outstanding;

   // Idling knobs, changed only while the block is drained.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   // Bumped by the stimulus to ask the receiver for one long hold-off.
   int unsigned hold_requests = 0;
   int unsigned words_sent    = 0;

   always #2 clock = ~clock;

   multi_port_serial_ring_buffers u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_port_index (req_port_index),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_request (rsp_tx_request),
      .rsp_tx_empty   (rsp_tx_empty),
      .rsp_rx_count   (rsp_rx_count)
   );

   ring_status_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_port_index (req_port_index),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_request (rsp_tx_request),
      .rsp_tx_empty   (rsp_tx_empty),
      .rsp_rx_count   (rsp_rx_count),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   // Receiver: stall at random, or hold off for a long stretch on request.
   initial begin : receiver
      int unsigned holds_served;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            // hold ready low long enough for the block to back up its input
            holds_served = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one word, idling first at the current rate, and hold it until taken.
   task automatic send_word(input cmd_type cmd, input logic [PORT_W-1:0] port,
                            input logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_port_index <= port;
      req_data_in    <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Any command on any port: the noise between well-formed bursts.
   task automatic send_any_word();
      send_word(cmd_type'($urandom_range(3)), PORT_W'($urandom_range(3)),
                BYTE_W'($urandom_range(255)));
   endtask

   // Drop valid and wait until every word sent has been answered.
   task automatic drain_replies();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // One idling phase: mostly fill-then-empty bursts on one port, some of them
   // long enough to overrun the ring, with single random words in between.
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall);
      int unsigned stop;
      int unsigned len;
      int unsigned extra;
      logic [PORT_W-1:0] port;
      logic rx_side;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      stop = words_sent + PHASE_WORDS;
      while (words_sent < stop) begin
         if ($urandom_range(99) < 60) begin
            port    = PORT_W'($urandom_range(3));
            rx_side = 1'($urandom_range(1));
            len     = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            extra   = $urandom_range(2);
            for (int i = 0; i < len; i++)
               send_word(rx_side ? CMD_RX_STORE : CMD_TX_WRITE, port,
                         BYTE_W'($urandom_range(255)));
            // read back past the end now and then to hit the empty ring
            for (int i = 0; i < len + extra; i++)
               send_word(rx_side ? CMD_RX_READ : CMD_TX_READY, port,
                         BYTE_W'($urandom_range(255)));
         end else begin
            send_any_word();
         end
      end
      drain_replies();
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_TX_WRITE;
      req_port_index = '0;
      req_data_in    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty rings straight out of reset: zero read, nothing to transmit.
      send_word(CMD_RX_READ,  2'd0, 8'h3C);
      send_word(CMD_TX_READY, 2'd0, 8'hC3);
      // Transmit extremes, then drain past empty so the request flag clears.
      send_word(CMD_TX_WRITE, 2'd0, 8'hFF);
      send_word(CMD_TX_WRITE, 2'd0, 8'h00);
      send_word(CMD_TX_READY, 2'd0, 8'h00);
      send_word(CMD_TX_READY, 2'd0, 8'hFF);
      send_word(CMD_TX_READY, 2'd0, 8'h00);
      // Receive extremes, then read one past empty for the stale byte.
      send_word(CMD_RX_STORE, 2'd3, 8'hFF);
      send_word(CMD_RX_STORE, 2'd3, 8'h00);
      send_word(CMD_RX_STORE, 2'd3, 8'h5A);
      for (int i = 0; i < 4; i++)
         send_word(CMD_RX_READ, 2'd3, 8'hFF);
      // Every port on its own rings.
      send_word(CMD_TX_WRITE, 2'd1, 8'hA5);
      send_word(CMD_TX_WRITE, 2'd2, 8'h5A);
      send_word(CMD_TX_WRITE, 2'd3, 8'h81);
      send_word(CMD_TX_READY, 2'd1, 8'h00);
      send_word(CMD_TX_READY, 2'd2, 8'h00);
      send_word(CMD_TX_READY, 2'd3, 8'h00);
      send_word(CMD_RX_STORE, 2'd1, 8'hAA);
      send_word(CMD_RX_STORE, 2'd2, 8'h55);
      send_word(CMD_RX_READ,  2'd1, 8'h00);
      send_word(CMD_RX_READ,  2'd2, 8'h00);
      // Pause until every directed word has come back.
      drain_replies();

      // Long receiver hold-off while words keep coming, so the input stalls.
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 40; i++)
         send_any_word();
      drain_replies();

      run_phase(0, 0);
      run_phase(73, 0);
      run_phase(0, 73);
      run_phase(18, 18);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Give up on a hung handshake.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
src/mpsrb_pkg.sv
src/mpsrb_ring_mem.sv
src/mpsrb_ctrl.sv
src/multi_port_serial_ring_buffers.sv
tb/ring_status_checker.sv
tb/tb_top.sv
